FILE: hdl/ath_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_pkg
// Shared widths, codes and types of the allocation tracker.
// ----------------------------------------------------------------------------
package ath_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int NUM_BIN_DEF     = 10;
   localparam int BIN_WIDTH_DEF   = 100;

   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 32;
   localparam int BIN_IDX_W  = 4;
   localparam int STATUS_W   = 2;
   localparam int TOTAL_W    = 48;
   localparam int LIVE_OUT_W = 7;
   localparam int COUNT_W    = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_REALLOC  = 2'd2,
      CMD_READ_BIN = 2'd3
   } ath_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE     = 2'd0,
      STAT_NOTFOUND = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NULL     = 2'd3
   } ath_status_type;

   // bin divider status toward the top level
   typedef struct packed {
      logic done;
      logic in_range;
   } ath_div_stat_type;

endpackage
`default_nettype wire

FILE: hdl/ath_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_req_if
// Request channel: one heap event item per handshake.
// ----------------------------------------------------------------------------
interface ath_req_if;
   import ath_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [ADDR_W-1:0]    addr;
   logic [ADDR_W-1:0]    new_addr;
   logic [SIZE_W-1:0]    size;
   logic [BIN_IDX_W-1:0] bin_index;

   modport source (output valid, cmd, addr, new_addr, size, bin_index, input ready);
   modport sink   (input valid, cmd, addr, new_addr, size, bin_index, output ready);

endinterface
`default_nettype wire

FILE: hdl/ath_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface ath_rsp_if;
   import ath_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SIZE_W-1:0]     removed_size;
   logic [TOTAL_W-1:0]    bytes_allocated;
   logic [TOTAL_W-1:0]    bytes_freed;
   logic [LIVE_OUT_W-1:0] live_entries;
   logic [COUNT_W-1:0]    bin_value;

   modport source (output valid, status, removed_size, bytes_allocated, bytes_freed,
                   live_entries, bin_value, input ready);
   modport sink   (input valid, status, removed_size, bytes_allocated, bytes_freed,
                   live_entries, bin_value, output ready);

endinterface
`default_nettype wire

FILE: hdl/ath_bin_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ath_bin_div
// Histogram bin of a size: quotient by BIN_WIDTH, one subtract per cycle,
// capped at NUM_BIN.
// ----------------------------------------------------------------------------
module ath_bin_div #(
   parameter int NUM_BIN   = ath_pkg::NUM_BIN_DEF,
   parameter int BIN_WIDTH = ath_pkg::BIN_WIDTH_DEF,
   localparam int QW       = $clog2(NUM_BIN + 1),
   localparam int BIN_AW   = (NUM_BIN > 1) ? $clog2(NUM_BIN) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ath_pkg::SIZE_W-1:0] size,
   output ath_pkg::ath_div_stat_type stat,
   output logic [BIN_AW-1:0]        bin
);
   import ath_pkg::*;

   logic [SIZE_W-1:0] rem_ff;
   logic [QW-1:0]     quo_ff;
   logic              run_ff;
   logic              step;

   assign step = (rem_ff >= SIZE_W'(BIN_WIDTH)) && (quo_ff < QW'(NUM_BIN));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && !step) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= size;
         quo_ff <= '0;
      end else if (run_ff && step) begin
         rem_ff <= rem_ff - SIZE_W'(BIN_WIDTH);
         quo_ff <= quo_ff + QW'(1);
      end
   end

   assign stat.done     = !run_ff;
   assign stat.in_range = quo_ff < QW'(NUM_BIN);
   assign bin           = BIN_AW'(quo_ff);

endmodule
`default_nettype wire

FILE: hdl/allocation_tracker_histogram_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// allocation_tracker_histogram_core
// Live allocation table with byte totals and a size histogram.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one heap event item (alloc, free, realloc, bin read);
//    rsp_chan returns exactly one result item for each, in order.
//  - Handshakes are valid/ready; an item moves when both are high.
//  - Table events scan all TABLE_DEPTH entries of the address/size memories,
//    one entry per cycle, to find the matching address and the lowest free
//    slot in the same pass. The scan sets the time from accept to result;
//    an item that bumps a histogram bin also passes a histogram increment
//    step. The bin divider runs alongside and adds wait only when NUM_BIN
//    is at least TABLE_DEPTH.
//  - Bin reads pass a histogram read step; null events go straight to result.
//  - One item is worked on at a time; the next item can be accepted in the cycle
//    its predecessor's result is first offered. The result sits in an output
//    register, so a stall on rsp_chan holds the block only once a second
//    result is ready.
//  - Synchronous reset empties the table, zeroes totals and the histogram;
//    no clearing pass is needed (valid bits live in flops). ready is low
//    during reset.
// ----------------------------------------------------------------------------
module allocation_tracker_histogram_core #(
   parameter int TABLE_DEPTH = ath_pkg::TABLE_DEPTH_DEF,
   parameter int NUM_BIN     = ath_pkg::NUM_BIN_DEF,
   parameter int BIN_WIDTH   = ath_pkg::BIN_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ath_req_if.sink    req_chan,
   ath_rsp_if.source  rsp_chan
);
   import ath_pkg::*;

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int LIVE_W = $clog2(TABLE_DEPTH + 1);
   localparam int BIN_AW = (NUM_BIN > 1) ? $clog2(NUM_BIN) : 1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_CMPW   = 7'b0000100,
      ST_APPLY  = 7'b0001000,
      ST_HINC   = 7'b0010000,
      ST_HQRY   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } ath_state_type;

   ath_state_type state_ff, state_in;

   // item decode, latched at accept
   logic [ADDR_W-1:0] drop_addr_ff, rec_addr_ff;
   logic [SIZE_W-1:0] rec_size_ff;
   logic              do_drop_ff, do_record_ff, clr_empty_ff, is_query_ff, qin_range_ff;
   logic [BIN_AW-1:0] qidx_ff;

   // scan and compare stage
   logic [AW-1:0]     scan_ff, cmp_idx_ff;
   logic              cmp_v_ff, cmp_valid_ff;
   logic              found_ff, free_found_ff;
   logic [AW-1:0]     match_ff, free_ff;
   logic [SIZE_W-1:0] match_bytes_ff;

   // live table: address/size memories, valid bits in flops
   logic [ADDR_W-1:0]      entry_address_mem [TABLE_DEPTH];
   logic [SIZE_W-1:0]      entry_bytes_mem   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] entry_valid_ff;
   logic [TABLE_DEPTH-1:0] entry_valid_in;
   logic [ADDR_W-1:0]      tbl_rd_addr_ff;
   logic [SIZE_W-1:0]      tbl_rd_bytes_ff;

   // histogram memory, valid bits give the cleared value
   logic [COUNT_W-1:0] hist_mem [NUM_BIN];
   logic [NUM_BIN-1:0] hist_vld_ff;
   logic [COUNT_W-1:0] hist_rd_ff;
   logic               hist_re, hist_we;
   logic [BIN_AW-1:0]  hist_ra;
   logic [COUNT_W-1:0] hist_base, hist_wdata;

   // totals and per-item result
   logic [TOTAL_W-1:0]  alloc_tot_ff, freed_tot_ff;
   logic [LIVE_W-1:0]   live_ff;
   logic [STATUS_W-1:0] st_ff;
   logic [SIZE_W-1:0]   removed_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   o_status_ff;
   logic [SIZE_W-1:0]     o_removed_ff;
   logic [TOTAL_W-1:0]    o_alloc_ff, o_freed_ff;
   logic [LIVE_OUT_W-1:0] o_live_ff;
   logic [COUNT_W-1:0]    o_bin_ff;

   // bin divider
   ath_div_stat_type  div_stat;
   logic [BIN_AW-1:0] div_bin;
   logic              div_start;

   // accept decode
   logic              accept;
   logic              dec_null, dec_drop, dec_record, dec_clr, dec_query;
   logic [ADDR_W-1:0] dec_rec_addr;

   // apply-step values
   logic [AW-1:0]     slot;
   logic              slot_avail, rec_ok;
   logic [LIVE_W-1:0] live_next;
   logic [TOTAL_W:0]  alloc_sum, freed_sum;
   logic              out_load;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign div_start      = accept;

   ath_bin_div #(
      .NUM_BIN   (NUM_BIN),
      .BIN_WIDTH (BIN_WIDTH)
   ) u_bin_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .size  (dec_record ? req_chan.size : '0),
      .stat  (div_stat),
      .bin   (div_bin)
   );

   // normalize the command into drop/record steps
   always_comb begin
      dec_null     = 1'b0;
      dec_drop     = 1'b0;
      dec_record   = 1'b0;
      dec_clr      = 1'b0;
      dec_query    = 1'b0;
      dec_rec_addr = req_chan.addr;
      case (ath_cmd_type'(req_chan.cmd))
         CMD_ALLOC: begin
            dec_null   = (req_chan.addr == '0);
            dec_record = !dec_null;
         end
         CMD_FREE: begin
            dec_null = (req_chan.addr == '0);
            dec_drop = !dec_null;
            dec_clr  = !dec_null;
         end
         CMD_REALLOC: begin
            dec_rec_addr = req_chan.new_addr;
            if (req_chan.addr == '0) begin
               // null old address: plain alloc of the new one
               dec_null   = (req_chan.new_addr == '0);
               dec_record = !dec_null;
            end else if (req_chan.size == '0) begin
               // zero size: plain free
               dec_drop = 1'b1;
               dec_clr  = 1'b1;
            end else if (req_chan.new_addr == '0) begin
               dec_null = 1'b1;   // failed realloc
            end else begin
               dec_drop   = 1'b1;
               dec_record = 1'b1;
            end
         end
         CMD_READ_BIN: begin
            dec_query = 1'b1;
         end
         default: begin
            dec_null = 1'b1;
         end
      endcase
   end

   // slot choice: lowest free index, counting the one this item drops
   assign slot_avail = free_found_ff || found_ff;
   assign slot       = (found_ff && (!free_found_ff || (match_ff < free_ff))) ? match_ff
                                                                              : free_ff;
   assign rec_ok     = do_record_ff && slot_avail;
   assign live_next  = live_ff - LIVE_W'(found_ff) + LIVE_W'(rec_ok);
   assign alloc_sum  = {1'b0, alloc_tot_ff} + (TOTAL_W + 1)'(rec_size_ff);
   assign freed_sum  = {1'b0, freed_tot_ff} + (TOTAL_W + 1)'(match_bytes_ff);
   assign out_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (dec_null) begin
                  state_in = ST_FINISH;
               end else if (dec_query) begin
                  state_in = ST_HQRY;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff == AW'(TABLE_DEPTH - 1)) state_in = ST_CMPW;
         end
         ST_CMPW: begin
            if (div_stat.done) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = (rec_ok && div_stat.in_range) ? ST_HINC : ST_FINISH;
         end
         ST_HINC:   state_in = ST_FINISH;
         ST_HQRY:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_load) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (accept) begin
         drop_addr_ff <= req_chan.addr;
         rec_addr_ff  <= dec_rec_addr;
         rec_size_ff  <= req_chan.size;
         do_drop_ff   <= dec_drop;
         do_record_ff <= dec_record;
         clr_empty_ff <= dec_clr;
         is_query_ff  <= dec_query;
         qin_range_ff <= ({3'b000, req_chan.bin_index} < 7'(NUM_BIN));
         qidx_ff      <= BIN_AW'(req_chan.bin_index);
      end
   end

   // scan counter and compare pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_v_ff <= 1'b0;
      end else begin
         cmp_v_ff <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scan_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         scan_ff <= scan_ff + AW'(1);
      end
      cmp_idx_ff   <= scan_ff;
      cmp_valid_ff <= entry_valid_ff[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmp_v_ff) begin
         // first valid hit on the address wins
         if (do_drop_ff && cmp_valid_ff && !found_ff && (tbl_rd_addr_ff == drop_addr_ff)) begin
            found_ff       <= 1'b1;
            match_ff       <= cmp_idx_ff;
            match_bytes_ff <= tbl_rd_bytes_ff;
         end
         if (!cmp_valid_ff && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_ff       <= cmp_idx_ff;
         end
      end
   end

   // table memories: one read and one write port
   always_ff @(posedge clock) begin
      if ((state_ff == ST_APPLY) && rec_ok) begin
         entry_address_mem[slot] <= rec_addr_ff;
         entry_bytes_mem[slot]   <= rec_size_ff;
      end
      tbl_rd_addr_ff  <= entry_address_mem[scan_ff];
      tbl_rd_bytes_ff <= entry_bytes_mem[scan_ff];
   end

   // drop first, then record; a record into the dropped slot keeps it valid
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (found_ff) entry_valid_in[match_ff] = 1'b0;
      if (rec_ok)   entry_valid_in[slot]     = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (state_ff == ST_APPLY) begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   // totals and per-item status
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_tot_ff <= '0;
         freed_tot_ff <= '0;
         live_ff      <= '0;
      end else if (state_ff == ST_APPLY) begin
         live_ff <= live_next;
         if (rec_ok) begin
            alloc_tot_ff <= alloc_sum[TOTAL_W] ? '1 : alloc_sum[TOTAL_W-1:0];
         end
         if (found_ff) begin
            freed_tot_ff <= freed_sum[TOTAL_W] ? '1 : freed_sum[TOTAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff      <= dec_null ? STAT_NULL : STAT_DONE;
         removed_ff <= '0;
      end else if (state_ff == ST_APPLY) begin
         if (do_record_ff && !slot_avail) begin
            st_ff <= STAT_FULL;
         end else if (do_drop_ff && !found_ff) begin
            st_ff <= STAT_NOTFOUND;
         end else begin
            st_ff <= STAT_DONE;
         end
         removed_ff <= found_ff ? match_bytes_ff : '0;
      end
   end

   // histogram: read-modify-write of one bin, bin reads for queries, clear by dropping valid bits
   always_comb begin
      hist_re = 1'b0;
      hist_ra = div_bin;
      if ((state_ff == ST_APPLY) && rec_ok && div_stat.in_range) begin
         hist_re = 1'b1;
      end else if ((state_ff == ST_HQRY) && qin_range_ff) begin
         hist_re = 1'b1;
         hist_ra = qidx_ff;
      end
   end

   assign hist_we    = (state_ff == ST_HINC);
   assign hist_base  = hist_vld_ff[div_bin] ? hist_rd_ff : '0;
   assign hist_wdata = (hist_base == '1) ? hist_base : hist_base + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[div_bin] <= hist_wdata;
      if (hist_re) hist_rd_ff <= hist_mem[hist_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if ((state_ff == ST_APPLY) && clr_empty_ff && (live_next == '0)) begin
         hist_vld_ff <= '0;
      end else if (hist_we) begin
         hist_vld_ff[div_bin] <= 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_status_ff  <= st_ff;
         o_removed_ff <= removed_ff;
         o_alloc_ff   <= alloc_tot_ff;
         o_freed_ff   <= freed_tot_ff;
         o_live_ff    <= LIVE_OUT_W'(live_ff);
         o_bin_ff     <= (is_query_ff && qin_range_ff && hist_vld_ff[qidx_ff]) ? hist_rd_ff
                                                                               : '0;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = o_status_ff;
   assign rsp_chan.removed_size    = o_removed_ff;
   assign rsp_chan.bytes_allocated = o_alloc_ff;
   assign rsp_chan.bytes_freed     = o_freed_ff;
   assign rsp_chan.live_entries    = o_live_ff;
   assign rsp_chan.bin_value       = o_bin_ff;

   // checks
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      $countones(entry_valid_ff) == live_ff)
      else $error("live count differs from valid bits");

   a_record_sets: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_APPLY) && rec_ok) |=> entry_valid_ff[$past(slot)])
      else $error("recorded slot not valid");

   a_found_drop: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_APPLY) && found_ff) |-> do_drop_ff)
      else $error("match on an item that drops nothing");

   a_div_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> div_stat.done)
      else $error("apply before bin is known");

endmodule
`default_nettype wire
